### hw/rtl/udwc_pkg.sv
// ----------------------------------------------------------------------------
// udwc_pkg: shared constants and decode functions
// Byte codes, code point ranges and the small UTF-8 decode and column width
// helpers used by the display width counter.
// ----------------------------------------------------------------------------
package udwc_pkg;

  localparam logic [7:0] ESC_BYTE   = 8'h1B;
  localparam logic [7:0] CSI_OPEN   = 8'h5B;
  localparam logic [7:0] CSI_FINAL_LO = 8'h40;
  localparam logic [7:0] CSI_FINAL_HI = 8'h7E;

  localparam int unsigned CP_BITS = 21;
  typedef logic [CP_BITS-1:0] code_point_t;
  typedef logic [1:0]         col_inc_t;
  typedef logic [2:0]         seq_len_t;

  localparam code_point_t CP_VS16     = 21'h00FE0F;
  localparam code_point_t CP_ZWJ      = 21'h00200D;
  localparam code_point_t CP_COMB_LO  = 21'h000300;
  localparam code_point_t CP_COMB_HI  = 21'h00036F;
  localparam code_point_t CP_HANGUL_LO = 21'h00AC00;
  localparam code_point_t CP_HANGUL_HI = 21'h00D7A3;
  localparam code_point_t CP_EMOJI_LO = 21'h01F300;
  localparam code_point_t CP_EMOJI_HI = 21'h01FAFF;
  localparam code_point_t CP_PLANE2_LO = 21'h020000;
  localparam code_point_t CP_PLANE3_HI = 21'h03FFFD;

  // Length of the UTF-8 form that a byte opens; 1 for anything else.
  function automatic seq_len_t lead_len(input logic [7:0] b);
    seq_len_t len;
    if (b[7] == 1'b0) begin
      len = 3'd1;
    end else if (b[7:5] == 3'b110) begin
      len = 3'd2;
    end else if (b[7:4] == 4'b1110) begin
      len = 3'd3;
    end else if (b[7:3] == 5'b11110) begin
      len = 3'd4;
    end else begin
      len = 3'd1;
    end
    return len;
  endfunction

  // Terminal columns taken by one code point.
  function automatic col_inc_t cp_width(input code_point_t cp);
    col_inc_t w;
    logic     zero_w;
    logic     wide;
    zero_w = (cp == '0) || (cp == CP_VS16) || (cp == CP_ZWJ) ||
             (cp >= CP_COMB_LO && cp <= CP_COMB_HI);
    wide = (cp >= 21'h001100 && cp <= 21'h00115F) ||
           (cp >= 21'h002E80 && cp <= 21'h00A4CF) ||
           (cp >= CP_HANGUL_LO && cp <= CP_HANGUL_HI) ||
           (cp >= 21'h00F900 && cp <= 21'h00FAFF) ||
           (cp >= 21'h00FF00 && cp <= 21'h00FF60) ||
           (cp >= 21'h00FFE0 && cp <= 21'h00FFE6) ||
           (cp >= CP_EMOJI_LO && cp <= CP_EMOJI_HI) ||
           (cp >= 21'h01F1E6 && cp <= 21'h01F1FF) ||
           (cp >= 21'h002600 && cp <= 21'h0027BF) ||
           (cp >= 21'h002B00 && cp <= 21'h002BFF) ||
           (cp >= CP_PLANE2_LO && cp <= CP_PLANE3_HI);
    if (zero_w) begin
      w = 2'd0;
    end else if (wide) begin
      w = 2'd2;
    end else begin
      w = 2'd1;
    end
    return w;
  endfunction

  // A single byte taken as its own code point: only NUL is zero width.
  function automatic col_inc_t byte_width(input logic [7:0] b);
    return (b == 8'h00) ? 2'd0 : 2'd1;
  endfunction

  // Width of a two-byte string that ends the text.
  function automatic col_inc_t pair_width(input logic [7:0] x, input logic [7:0] y);
    col_inc_t w;
    if (x == ESC_BYTE && y == CSI_OPEN) begin
      w = 2'd0;
    end else if (lead_len(x) == 3'd2) begin
      w = cp_width({10'b0, x[4:0], y[5:0]});
    end else begin
      w = byte_width(x) + byte_width(y);
    end
    return w;
  endfunction

endpackage

### hw/rtl/utf8_display_width_counter.sv
// ----------------------------------------------------------------------------
// utf8_display_width_counter: terminal column width of a byte string
// Counts the display columns of a UTF-8 string with ANSI CSI sequences
// skipped, one byte per transaction, and gives the total on the last byte.
// ----------------------------------------------------------------------------
// The block takes one byte of text per input transaction, with end_of_text_i
// high on the final byte, and returns exactly one output transaction for
// each string: the total column width, saturated at 65535, with a flag that
// tells when the total ran past the counter range. ESC '[' starts a CSI
// sequence that is skipped through its final byte (0x40 to 0x7E). Other
// bytes are decoded as UTF-8 by the length that the lead byte announces,
// without checking continuation bytes, and every code point adds zero, one
// or two columns by fixed code point ranges. A multibyte form left
// unfinished at the end counts one column for its lead byte, and the bytes
// after it are counted again as a short string. A byte is accepted in every
// cycle unless the input stalls: it passes through an input register, and the
// decode and range compare logic then updates the running state; the total of
// a string lands in a result register at that same edge and is held there
// until it is taken. Only a result that is waiting at the output stalls the
// input, and only once a further final byte reaches the decode stage.
// ----------------------------------------------------------------------------
module utf8_display_width_counter #(
  parameter int unsigned WIDTH_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  text_byte_i,
  input  logic        end_of_text_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [15:0] column_width_o,
  output logic        width_saturated_o
);

  typedef enum logic [1:0] {
    MODE_NORMAL = 2'd0,
    MODE_CSI    = 2'd1
  } scan_mode_e;

  // Input register.
  logic       in_vld_q;
  logic [7:0] byte_q;
  logic       eot_q;

  // Scan state.
  scan_mode_e              mode_q, mode_d;
  logic [7:0]              pend_q [3];
  logic [2:0]              pend_we;
  logic [1:0]              pcount_q, pcount_d;
  udwc_pkg::seq_len_t      seqlen_q, seqlen_d;
  logic [WIDTH_BITS-1:0]   total_q, total_d;
  logic                    ovf_q, ovf_d;

  // Result register.
  logic        out_vld_q;
  logic [15:0] col_q;
  logic        sat_q;

  logic                    out_free;
  logic                    adv;
  udwc_pkg::seq_len_t      fresh_len;
  logic                    fresh_pend;
  udwc_pkg::col_inc_t      fresh_inc;
  udwc_pkg::col_inc_t      bw;
  udwc_pkg::code_point_t   full_cp;
  logic                    seq_done;
  udwc_pkg::col_inc_t      inc;
  logic [WIDTH_BITS:0]     sum;
  logic [WIDTH_BITS-1:0]   total_new;
  logic                    ovf_new;
  logic [31:0]             total_ext;

  // A byte in the input register moves on unless it would produce a result
  // while the result register is still full.
  assign out_free   = !out_vld_q || out_ready_i;
  assign adv        = in_vld_q && (!eot_q || out_free);
  assign in_ready_o = !in_vld_q || adv;

  always_comb begin
    fresh_len  = udwc_pkg::lead_len(byte_q);
    fresh_pend = (byte_q == udwc_pkg::ESC_BYTE) || (fresh_len > 3'd1);
    bw         = udwc_pkg::byte_width(byte_q);
    fresh_inc  = fresh_pend ? 2'd0 : bw;
    seq_done   = ({1'b0, pcount_q} + 3'd1 >= seqlen_q) || (pcount_q == 2'd3);

    case (seqlen_q)
      3'd2:    full_cp = {10'b0, pend_q[0][4:0], byte_q[5:0]};
      3'd3:    full_cp = {5'b0, pend_q[0][3:0], pend_q[1][5:0], byte_q[5:0]};
      default: full_cp = {pend_q[0][2:0], pend_q[1][5:0], pend_q[2][5:0], byte_q[5:0]};
    endcase

    mode_d   = mode_q;
    pcount_d = pcount_q;
    seqlen_d = seqlen_q;
    pend_we  = '0;
    inc      = 2'd0;

    if (eot_q) begin
      // The final byte closes whatever is pending; the state starts over.
      if (mode_q == MODE_CSI) begin
        inc = 2'd0;
      end else if (pcount_q == 2'd0) begin
        inc = bw;
      end else if (seqlen_q <= 3'd1) begin
        inc = (byte_q == udwc_pkg::CSI_OPEN) ? 2'd0 : 2'(2'd1 + bw);
      end else if (seq_done) begin
        inc = udwc_pkg::cp_width(full_cp);
      end else if (pcount_q == 2'd1) begin
        inc = 2'(2'd1 + bw);
      end else begin
        inc = 2'(2'd1 + udwc_pkg::pair_width(pend_q[1], byte_q));
      end
      mode_d   = MODE_NORMAL;
      pcount_d = '0;
      seqlen_d = '0;
    end else if (mode_q == MODE_CSI) begin
      if (byte_q >= udwc_pkg::CSI_FINAL_LO && byte_q <= udwc_pkg::CSI_FINAL_HI) begin
        mode_d = MODE_NORMAL;
      end
    end else if (pcount_q == 2'd0 || seqlen_q <= 3'd1) begin
      // Either a fresh byte, or the byte after a pending ESC.
      if (pcount_q != 2'd0 && byte_q == udwc_pkg::CSI_OPEN) begin
        mode_d   = MODE_CSI;
        pcount_d = '0;
        seqlen_d = '0;
      end else begin
        inc = (pcount_q != 2'd0) ? 2'(2'd1 + fresh_inc) : fresh_inc;
        if (fresh_pend) begin
          pend_we[0] = 1'b1;
          pcount_d   = 2'd1;
          seqlen_d   = (byte_q == udwc_pkg::ESC_BYTE) ? 3'd1 : fresh_len;
        end else begin
          pcount_d = '0;
          seqlen_d = '0;
        end
      end
    end else if (seq_done) begin
      inc      = udwc_pkg::cp_width(full_cp);
      pcount_d = '0;
      seqlen_d = '0;
    end else begin
      pend_we[pcount_q] = 1'b1;
      pcount_d          = pcount_q + 2'd1;
    end

    // Saturating add: the carry out means the total ran past its range.
    sum       = {1'b0, total_q} + (WIDTH_BITS + 1)'(inc);
    ovf_new   = ovf_q || sum[WIDTH_BITS];
    total_new = sum[WIDTH_BITS] ? '1 : sum[WIDTH_BITS-1:0];
    total_ext = 32'(total_new);

    if (eot_q) begin
      total_d = '0;
      ovf_d   = 1'b0;
    end else begin
      total_d = total_new;
      ovf_d   = ovf_new;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      byte_q    <= '0;
      eot_q     <= 1'b0;
      mode_q    <= MODE_NORMAL;
      for (int k = 0; k < 3; k++) begin
        pend_q[k] <= '0;
      end
      pcount_q  <= '0;
      seqlen_q  <= '0;
      total_q   <= '0;
      ovf_q     <= 1'b0;
      out_vld_q <= 1'b0;
      col_q     <= '0;
      sat_q     <= 1'b0;
    end else begin
      if (in_ready_o) begin
        in_vld_q <= in_valid_i;
      end
      if (in_ready_o && in_valid_i) begin
        byte_q <= text_byte_i;
        eot_q  <= end_of_text_i;
      end
      if (adv) begin
        mode_q   <= mode_d;
        pcount_q <= pcount_d;
        seqlen_q <= seqlen_d;
        total_q  <= total_d;
        ovf_q    <= ovf_d;
      end
      for (int k = 0; k < 3; k++) begin
        if (adv && pend_we[k]) begin
          pend_q[k] <= byte_q;
        end
      end
      if (adv && eot_q) begin
        out_vld_q <= 1'b1;
        col_q     <= (total_ext > 32'h0000_FFFF) ? 16'hFFFF : total_ext[15:0];
        sat_q     <= ovf_new || (total_ext > 32'h0000_FFFF);
      end else if (out_ready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  assign out_valid_o       = out_vld_q;
  assign column_width_o    = col_q;
  assign width_saturated_o = sat_q;

endmodule

### bench/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: display width counter check
// Feeds byte strings through the counter with random idling on both sides
// and checks every total and saturation flag against a scoreboard that
// tracks CSI skipping, UTF-8 decode and the end-of-string rescan.
// ----------------------------------------------------------------------------
module testbench;

  localparam int unsigned WIDTH_BITS = 16;

  // Code point ranges that render two columns wide.
  localparam int unsigned WIDE_LO [0:10] = '{
    32'h1100, 32'h2E80, udwc_pkg::CP_HANGUL_LO, 32'hF900, 32'hFF00, 32'hFFE0,
    udwc_pkg::CP_EMOJI_LO, 32'h1F1E6, 32'h2600, 32'h2B00, udwc_pkg::CP_PLANE2_LO
  };
  localparam int unsigned WIDE_HI [0:10] = '{
    32'h115F, 32'hA4CF, udwc_pkg::CP_HANGUL_HI, 32'hFAFF, 32'hFF60, 32'hFFE6,
    udwc_pkg::CP_EMOJI_HI, 32'h1F1FF, 32'h27BF, 32'h2BFF, udwc_pkg::CP_PLANE3_HI
  };
  // Zero-width points and the spans of each multibyte encoded length, used as
  // extra boundaries when the stimulus picks code points.
  localparam int unsigned PROBE_LO [0:6] = '{
    32'h0, udwc_pkg::CP_COMB_LO, udwc_pkg::CP_ZWJ, udwc_pkg::CP_VS16,
    32'h80, 32'h800, 32'h10000
  };
  localparam int unsigned PROBE_HI [0:6] = '{
    32'h0, udwc_pkg::CP_COMB_HI, udwc_pkg::CP_ZWJ, udwc_pkg::CP_VS16,
    32'h7FF, 32'hFFFF, 32'h1FFFFF
  };

  typedef enum logic {
    SCAN_TEXT,
    SCAN_CSI
  } scan_e;

  typedef struct packed {
    logic [15:0] cols;
    logic        sat;
  } width_result_t;

  // --------------------------------------------------------------------------
  // Scoreboard: tracks the string being scanned and queues one expected
  // width per string, produced when the final byte is accepted.
  // --------------------------------------------------------------------------
  class width_scoreboard;
    scan_e           mode;
    logic [2:0][7:0] held;
    int unsigned     held_n;
    int unsigned     unit_len;
    longint unsigned total;
    bit              sat_seen;
    width_result_t   expected_q[$];
    int unsigned     fail_count;

    function new();
      clear();
      fail_count = 0;
    endfunction

    function void clear();
      mode     = SCAN_TEXT;
      held     = '0;
      held_n   = 0;
      unit_len = 0;
      total    = 0;
      sat_seen = 1'b0;
    endfunction

    function int unsigned utf8_span(logic [7:0] c);
      if ((c & 8'h80) == 8'h00) return 1;
      if ((c & 8'hE0) == 8'hC0) return 2;
      if ((c & 8'hF0) == 8'hE0) return 3;
      if ((c & 8'hF8) == 8'hF0) return 4;
      return 1;
    endfunction

    function int unsigned columns_of(int unsigned cp);
      if (cp == 0 || cp == udwc_pkg::CP_VS16 || cp == udwc_pkg::CP_ZWJ) return 0;
      if (cp >= udwc_pkg::CP_COMB_LO && cp <= udwc_pkg::CP_COMB_HI) return 0;
      for (int k = 0; k < 11; k++) begin
        if (cp >= WIDE_LO[k] && cp <= WIDE_HI[k]) return 2;
      end
      return 1;
    endfunction

    // Code point of the len-byte form that starts at t[base].
    function int unsigned assemble(logic [3:0][7:0] t, int unsigned base,
                                   int unsigned len);
      case (len)
        2: return {t[base][4:0], t[base+1][5:0]};
        3: return {t[base][3:0], t[base+1][5:0], t[base+2][5:0]};
        4: return {t[base][2:0], t[base+1][5:0], t[base+2][5:0], t[base+3][5:0]};
        default: return t[base];
      endcase
    endfunction

    function void bump(int unsigned w);
      longint unsigned top;
      top = (64'd1 << WIDTH_BITS) - 1;
      if (total + w > top) begin
        total    = top;
        sat_seen = 1'b1;
      end else begin
        total += w;
      end
    endfunction

    // Parses the few bytes left at the end of a string as a string of their
    // own: CSI skipped, complete forms decoded, anything else byte by byte.
    function void rescan_tail(logic [3:0][7:0] t, int unsigned n);
      int unsigned i;
      int unsigned j;
      int unsigned len;
      logic [7:0]  c;
      bit          stop;
      i = 0;
      while (i < n) begin
        c = t[i];
        if (c == udwc_pkg::ESC_BYTE && i + 1 < n && t[i+1] == udwc_pkg::CSI_OPEN) begin
          j    = i + 2;
          stop = 1'b0;
          while (j < n && !stop) begin
            stop = (t[j] >= udwc_pkg::CSI_FINAL_LO && t[j] <= udwc_pkg::CSI_FINAL_HI);
            j++;
          end
          i = j;
        end else begin
          len = utf8_span(c);
          if (len > 1 && i + len <= n) begin
            bump(columns_of(assemble(t, i, len)));
            i += len;
          end else begin
            bump(columns_of(c));
            i++;
          end
        end
      end
    endfunction

    function void take_fresh(logic [7:0] b);
      int unsigned len;
      len = utf8_span(b);
      if (b == udwc_pkg::ESC_BYTE) begin
        held[0]  = b;
        held_n   = 1;
        unit_len = 1;
      end else if (len > 1) begin
        held[0]  = b;
        held_n   = 1;
        unit_len = len;
      end else begin
        bump(columns_of(b));
      end
    endfunction

    // Called once per accepted input transaction.
    function void note_byte(logic [7:0] b, bit is_final);
      logic [3:0][7:0] unit_bytes;
      int unsigned     k;
      int unsigned     len;
      width_result_t   r;
      unit_bytes = '0;
      if (is_final) begin
        // A CSI cut off by the end of the string simply counts nothing.
        if (mode != SCAN_CSI) begin
          for (k = 0; k < held_n && k < 3; k++) unit_bytes[k] = held[k];
          unit_bytes[k] = b;
          rescan_tail(unit_bytes, k + 1);
        end
        r.cols = (total > 64'hFFFF) ? 16'hFFFF : total[15:0];
        r.sat  = sat_seen | (total > 64'hFFFF);
        expected_q = {expected_q, r};
        clear();
      end else if (mode == SCAN_CSI) begin
        if (b >= udwc_pkg::CSI_FINAL_LO && b <= udwc_pkg::CSI_FINAL_HI) mode = SCAN_TEXT;
      end else if (held_n == 0) begin
        take_fresh(b);
      end else if (unit_len <= 1) begin
        // An ESC was waiting: '[' opens a CSI, anything else makes the ESC
        // a one-column character and is scanned on its own.
        held_n   = 0;
        unit_len = 0;
        if (b == udwc_pkg::CSI_OPEN) begin
          mode = SCAN_CSI;
        end else begin
          bump(columns_of(udwc_pkg::ESC_BYTE));
          take_fresh(b);
        end
      end else if (held_n + 1 >= unit_len || held_n >= 3) begin
        for (k = 0; k < held_n && k < 3; k++) unit_bytes[k] = held[k];
        unit_bytes[k] = b;
        len = (unit_len > 4) ? 4 : unit_len;
        bump(columns_of(assemble(unit_bytes, 0, len)));
        held_n   = 0;
        unit_len = 0;
      end else begin
        held[held_n] = b;
        held_n++;
      end
    endfunction

    task report(string msg);
      $display("MISMATCH @%0t: %s", $time, msg);
      fail_count++;
    endtask

    task check_result(logic [15:0] cols, logic sat);
      width_result_t want;
      if (expected_q.size() == 0) begin
        report($sformatf("result with no string pending: width %0d sat %0b", cols, sat));
        return;
      end
      want = expected_q.pop_front();
      if (cols !== want.cols) begin
        report($sformatf("column_width %0d, expected %0d", cols, want.cols));
      end
      if (sat !== want.sat) begin
        report($sformatf("width_saturated %0b, expected %0b", sat, want.sat));
      end
    endtask
  endclass

  // --------------------------------------------------------------------------
  // Clock, reset and the block under test. Every input holds a known value
  // from time zero.
  // --------------------------------------------------------------------------
  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [7:0]  text_byte_i = 8'h00;
  logic        end_of_text_i = 1'b0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [15:0] column_width_o;
  logic        width_saturated_o;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  utf8_display_width_counter #(
    .WIDTH_BITS(WIDTH_BITS)
  ) uut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .text_byte_i      (text_byte_i),
    .end_of_text_i    (end_of_text_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .column_width_o   (column_width_o),
    .width_saturated_o(width_saturated_o)
  );

  width_scoreboard sb = new();

  logic [7:0]  text_q[$];     // bytes of the string being built
  int unsigned items_sent;
  bit          tx_quiet;      // sender runs without gaps while set
  bit          rx_quiet;      // receiver starts no new stall while set
  int unsigned rx_hold;

  // --------------------------------------------------------------------------
  // Result side. The handshake is sampled at the rising edge, before any
  // nonblocking update of that edge lands, and the next ready is driven
  // with a nonblocking assignment. Stalls are mostly short, a few long.
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        sb.check_result(column_width_o, width_saturated_o);
      end
      if (rx_hold > 0) begin
        rx_hold--;
        out_ready_i <= 1'b0;
      end else if (rx_quiet || $urandom_range(0, 99) < 65) begin
        out_ready_i <= 1'b1;
      end else begin
        rx_hold     = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40)
                                                  : $urandom_range(0, 2);
        out_ready_i <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Input side.
  // --------------------------------------------------------------------------
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (tx_quiet || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(5, 30);
  endfunction

  // Drives one transaction and waits until it is taken. Each call starts
  // and ends right after a rising edge, so a valid that stays high from one
  // transaction to the next gets only one assignment in that step.
  task automatic send_byte(input logic [7:0] b, input bit is_final);
    int unsigned gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    text_byte_i   <= b;
    end_of_text_i <= is_final;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    sb.note_byte(b, is_final);
  endtask

  // Sends the built string, flagging its last byte as the end of the text.
  task automatic send_text();
    int unsigned n;
    n = text_q.size();
    for (int unsigned i = 0; i < n; i++) send_byte(text_q[i], i == n - 1);
    items_sent += n;
    text_q.delete();
  endtask

  // Holds the input idle until every queued result has been checked.
  task automatic drain();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (sb.expected_q.size() != 0);
  endtask

  // --------------------------------------------------------------------------
  // String builders.
  // --------------------------------------------------------------------------
  // Continuation byte; now and then with odd top bits, which the decoder is
  // meant to ignore.
  function automatic logic [7:0] cont(input logic [5:0] bits);
    logic [1:0] top;
    top = ($urandom_range(0, 6) == 0) ? 2'($urandom_range(0, 3)) : 2'b10;
    return {top, bits};
  endfunction

  // Adds one byte to the end of the string being built.
  task automatic append_byte(input logic [7:0] b);
    text_q = {text_q, b};
  endtask

  // Encodes a code point in its shortest form, or sometimes one byte longer.
  task automatic push_code_point(input int unsigned cp);
    int unsigned len;
    len = (cp < 32'h80) ? 1 : (cp < 32'h800) ? 2 : (cp < 32'h10000) ? 3 : 4;
    if (len < 4 && $urandom_range(0, 9) == 0) len++;
    case (len)
      1: append_byte(cp[7:0]);
      2: begin
        append_byte({3'b110, cp[10:6]});
        append_byte(cont(cp[5:0]));
      end
      3: begin
        append_byte({4'b1110, cp[15:12]});
        append_byte(cont(cp[11:6]));
        append_byte(cont(cp[5:0]));
      end
      default: begin
        append_byte({5'b11110, cp[20:18]});
        append_byte(cont(cp[17:12]));
        append_byte(cont(cp[11:6]));
        append_byte(cont(cp[5:0]));
      end
    endcase
  endtask

  // Picks a code point on or next to the edge of a wide range or probe span, or inside.
  function automatic int unsigned pick_code_point();
    int unsigned lo;
    int unsigned hi;
    int unsigned k;
    if ($urandom_range(0, 1) == 0) begin
      k  = $urandom_range(0, 10);
      lo = WIDE_LO[k];
      hi = WIDE_HI[k];
    end else begin
      k  = $urandom_range(0, 6);
      lo = PROBE_LO[k];
      hi = PROBE_HI[k];
    end
    case ($urandom_range(0, 5))
      0: return (lo > 0) ? lo - 1 : lo;
      1: return lo;
      2: return hi;
      3: return (hi < 32'h1FFFFF) ? hi + 1 : hi;
      default: return $urandom_range(hi, lo);
    endcase
  endfunction

  // A lead byte with fewer continuation bytes than it announces.
  task automatic push_cut_form(input int unsigned extra_max);
    int unsigned len;
    int unsigned extra;
    len = $urandom_range(2, 4);
    case (len)
      2: append_byte({3'b110, 5'($urandom_range(0, 31))});
      3: append_byte({4'b1110, 4'($urandom_range(0, 15))});
      default: append_byte({5'b11110, 3'($urandom_range(0, 7))});
    endcase
    extra = $urandom_range(0, (len - 2 < extra_max) ? len - 2 : extra_max);
    repeat (extra) append_byte(cont(6'($urandom_range(0, 63))));
  endtask

  task automatic push_csi_param();
    logic [7:0] p;
    p = 8'($urandom_range(0, 255));
    if ($urandom_range(0, 9) < 7) p = 8'($urandom_range(8'h30, 8'h3F));
    if (p >= udwc_pkg::CSI_FINAL_LO && p <= udwc_pkg::CSI_FINAL_HI) p = 8'h3B;
    append_byte(p);
  endtask

  task automatic push_unit();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 30) begin
      append_byte(8'($urandom_range(8'h20, 8'h7E)));
    end else if (r < 38) begin
      if ($urandom_range(0, 4) == 0) begin
        append_byte(8'h7F);
      end else begin
        append_byte(8'($urandom_range(8'h00, 8'h1F)) & ~8'h04);
      end
    end else if (r < 70) begin
      push_code_point(pick_code_point());
    end else if (r < 80) begin
      // Complete CSI sequence.
      append_byte(udwc_pkg::ESC_BYTE);
      append_byte(udwc_pkg::CSI_OPEN);
      repeat ($urandom_range(0, 4)) push_csi_param();
      case ($urandom_range(0, 3))
        0: append_byte(udwc_pkg::CSI_FINAL_LO);
        1: append_byte(udwc_pkg::CSI_FINAL_HI);
        2: append_byte(8'h6D);
        default: append_byte(8'($urandom_range(udwc_pkg::CSI_FINAL_LO,
                                                udwc_pkg::CSI_FINAL_HI)));
      endcase
    end else if (r < 85) begin
      append_byte(udwc_pkg::ESC_BYTE);
    end else if (r < 90) begin
      append_byte(($urandom_range(0, 1) == 0) ? 8'($urandom_range(8'h80, 8'hBF))
                                              : 8'($urandom_range(8'hF8, 8'hFF)));
    end else if (r < 95) begin
      push_cut_form(2);
    end else begin
      append_byte(8'($urandom_range(0, 255)));
    end
  endtask

  // Endings that leave something unfinished for the final rescan.
  task automatic push_broken_tail();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 40) begin
      push_cut_form(2);
    end else if (r < 55) begin
      append_byte(udwc_pkg::ESC_BYTE);
    end else if (r < 70) begin
      append_byte(udwc_pkg::ESC_BYTE);
      append_byte(udwc_pkg::CSI_OPEN);
      repeat ($urandom_range(0, 2)) push_csi_param();
    end else begin
      push_cut_form(0);
      repeat ($urandom_range(1, 2)) begin
        case ($urandom_range(0, 3))
          0: append_byte(udwc_pkg::ESC_BYTE);
          1: append_byte(udwc_pkg::CSI_OPEN);
          2: append_byte(cont(6'($urandom_range(0, 63))));
          default: append_byte(8'($urandom_range(0, 255)));
        endcase
      end
    end
  endtask

  // A string of printable ASCII, one column per byte, with no gaps.
  task automatic send_plain_run(input int unsigned n);
    tx_quiet = 1'b1;
    for (int unsigned i = 0; i < n; i++) begin
      send_byte(8'($urandom_range(8'h20, 8'h7E)), i == n - 1);
    end
    items_sent += n;
  endtask

  // --------------------------------------------------------------------------
  // Main sequence.
  // --------------------------------------------------------------------------
  initial begin
    items_sent = 0;
    tx_quiet   = 1'b0;
    rx_quiet   = 1'b0;
    rx_hold    = 0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed strings: a lone letter and a lone NUL, a skipped CSI, ESC
    // before a plain byte at the end, wide, zero-width and 4-byte forms, an
    // unfinished form, a CSI cut off by the end, and a cut 4-byte lead
    // followed by ESC '['.
    text_q = '{8'h41};
    send_text();
    text_q = '{8'h00};
    send_text();
    text_q = '{udwc_pkg::ESC_BYTE, udwc_pkg::CSI_OPEN, 8'h6D, 8'h42};
    send_text();
    text_q = '{udwc_pkg::ESC_BYTE, 8'h78};
    send_text();
    text_q = '{8'hE4, 8'hB8, 8'h80};
    send_text();
    text_q = '{8'hCC, 8'h81};
    send_text();
    text_q = '{8'hF0, 8'h9F, 8'h98, 8'h80};
    send_text();
    text_q = '{8'hE4, 8'hB8};
    send_text();
    text_q = '{udwc_pkg::ESC_BYTE, udwc_pkg::CSI_OPEN, 8'h31};
    send_text();
    text_q = '{8'hF0, udwc_pkg::ESC_BYTE, udwc_pkg::CSI_OPEN};
    send_text();

    // The sender holds off until every result is back, then sends one
    // plain string with no gaps between its bytes.
    drain();
    send_plain_run(48);
    tx_quiet = 1'b0;

    // Random strings: mostly well-formed units with random content, with
    // noise bytes mixed in and some strings ending mid-form or mid-CSI.
    while (items_sent < 950) begin
      tx_quiet = ($urandom_range(0, 7) == 0);
      rx_quiet = ($urandom_range(0, 7) == 0);
      repeat (($urandom_range(0, 99) < 85) ? $urandom_range(1, 8)
                                           : $urandom_range(9, 40)) begin
        push_unit();
      end
      if ($urandom_range(0, 99) < 35) push_broken_tail();
      send_text();
    end
    tx_quiet = 1'b0;
    rx_quiet = 1'b0;

    // Let everything drain, then watch a little longer for stray results.
    drain();
    repeat (20) @(posedge clk_i);
    if (sb.fail_count == 0 && sb.expected_q.size() == 0) begin
      $display("** utf8_display_width_counter: PASSED **");
    end else begin
      $display("** utf8_display_width_counter: FAILED **");
    end
    $finish;
  end

  // Watchdog, far beyond the slowest legal run.
  initial begin
    #50_000_000;
    $display("** utf8_display_width_counter: FAILED **");
    $finish;
  end

endmodule

### utf8_display_width_counter.f
hw/rtl/udwc_pkg.sv
hw/rtl/utf8_display_width_counter.sv
bench/testbench.sv
